@@ hw/rtl/gyro_still_bias_calibrator_assert.svh @@
// assertion helpers for the still-bias calibrator
`ifndef GYRO_STILL_BIAS_CALIBRATOR_ASSERT_SVH
`define GYRO_STILL_BIAS_CALIBRATOR_ASSERT_SVH

// same-cycle implication
`define GSBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GSBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gsbc_pkg.sv @@
`timescale 1ns / 1ps

package gsbc_pkg;

    localparam int WindowLog2       = 7;
    localparam int WindowSamples    = 1 << WindowLog2;
    localparam int SlotW            = WindowLog2;
    localparam int SmpW             = 16;
    localparam int TickW            = 32;
    localparam int SqOneW           = 2 * SmpW - 1;
    localparam int SumW             = SmpW + WindowLog2;
    localparam int SqW              = SqOneW + WindowLog2;
    localparam int RateW            = SmpW + 1;
    localparam int LimitW           = 31;
    localparam int IntervalW        = 16;
    localparam int LastW            = TickW + 1;
    localparam int CfgIdxW          = 2;
    localparam int CfgDataW         = 32;
    localparam int VarLimitReset    = 2000;
    localparam int MinIntervalReset = 1000;

    typedef enum logic [CfgIdxW-1:0] {
        CfgVarLimit    = 2'd0,
        CfgMinInterval = 2'd1
    } t_cfg_reg;

    // index 0 is x, 1 is y, 2 is z
    typedef logic [2:0][SmpW-1:0] t_axes;

    typedef struct packed {
        t_axes                  smp;
        logic [TickW-1:0]       tick;
        logic                   full;
        logic [2:0][SumW-1:0]   sum;
        logic [2:0][SqW-1:0]    sq;
    } t_stats;

endpackage

@@ hw/rtl/gsbc_window.sv @@
`timescale 1ns / 1ps

module gsbc_window import gsbc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_axes            i_sample,
    input  logic [TickW-1:0] i_tick,
    output logic             o_valid,
    input  logic             i_stall,
    output t_stats           o_stats
);

    t_axes            r_ring [WindowSamples];
    t_axes            r_rd;
    logic [SlotW-1:0] r_slot;
    logic             r_full;

    logic             r_a_valid;
    t_axes            r_a_smp;
    logic [TickW-1:0] r_a_tick;
    logic             r_a_had_old;
    logic             r_a_full;
    logic [SqOneW-1:0] r_a_sqn [3];

    logic             r_b_valid;
    t_axes            r_b_smp;
    logic [TickW-1:0] r_b_tick;
    logic             r_b_full;
    logic [RateW-1:0] r_b_dsum [3];
    logic [SqOneW-1:0] r_b_sqn [3];
    logic [SqOneW-1:0] r_b_sqo [3];

    logic [2:0][SumW-1:0] r_sum;
    logic [2:0][SqW-1:0]  r_sq;
    logic [2:0][SumW-1:0] n_sum;
    logic [2:0][SqW-1:0]  n_sq;

    logic             r_c_valid;
    t_stats           r_c_stats;

    logic             rdy_a;
    logic             rdy_b;
    logic             rdy_c;
    logic             accept;

    logic signed [2*SmpW-1:0] sq_in  [3];
    logic signed [2*SmpW-1:0] sq_old [3];
    logic signed [RateW-1:0]  dsum   [3];

    assign rdy_c   = !r_c_valid || !i_stall;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign rdy_a   = !r_a_valid || rdy_b;
    assign accept  = i_valid && rdy_a;
    assign o_stall = !rdy_a;
    assign o_valid = r_c_valid;
    assign o_stats = r_c_stats;

    // read-before-write: the old entry at this slot leaves the window
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_slot] <= i_sample;
            r_rd           <= r_ring[r_slot];
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sq_in[a]  = $signed(i_sample[a]) * $signed(i_sample[a]);
            sq_old[a] = $signed(r_rd[a]) * $signed(r_rd[a]);
            if (r_a_had_old) begin
                dsum[a] = $signed({r_a_smp[a][SmpW-1], r_a_smp[a]})
                        - $signed({r_rd[a][SmpW-1], r_rd[a]});
            end else begin
                dsum[a] = $signed({r_a_smp[a][SmpW-1], r_a_smp[a]});
            end
            n_sum[a] = r_sum[a] + {{(SumW-RateW){r_b_dsum[a][RateW-1]}}, r_b_dsum[a]};
            n_sq[a]  = r_sq[a] + {{(SqW-SqOneW){1'b0}}, r_b_sqn[a]}
                     - {{(SqW-SqOneW){1'b0}}, r_b_sqo[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_full    <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_sum     <= '0;
            r_sq      <= '0;
        end else begin
            if (accept) begin
                r_slot <= r_slot + 1'b1;
                if (r_slot == SlotW'(WindowSamples - 1)) begin
                    r_full <= 1'b1;
                end
            end
            if (rdy_a) begin
                r_a_valid <= accept;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (r_b_valid && rdy_c) begin
                r_sum <= n_sum;
                r_sq  <= n_sq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_smp     <= i_sample;
            r_a_tick    <= i_tick;
            r_a_had_old <= r_full;
            r_a_full    <= r_full || (r_slot == SlotW'(WindowSamples - 1));
            for (int a = 0; a < 3; a++) begin
                r_a_sqn[a] <= sq_in[a][SqOneW-1:0];
            end
        end
        if (r_a_valid && rdy_b) begin
            r_b_smp  <= r_a_smp;
            r_b_tick <= r_a_tick;
            r_b_full <= r_a_full;
            for (int a = 0; a < 3; a++) begin
                r_b_dsum[a] <= dsum[a];
                r_b_sqn[a]  <= r_a_sqn[a];
                r_b_sqo[a]  <= r_a_had_old ? sq_old[a][SqOneW-1:0] : '0;
            end
        end
        if (r_b_valid && rdy_c) begin
            r_c_stats.smp  <= r_b_smp;
            r_c_stats.tick <= r_b_tick;
            r_c_stats.full <= r_b_full;
            r_c_stats.sum  <= n_sum;
            r_c_stats.sq   <= n_sq;
        end
    end

endmodule

@@ hw/rtl/gyro_still_bias_calibrator.sv @@
// channel   direction  handshake                        payload
// sample    in         i_valid / o_stall                i_gyro_x/y/z, i_now_tick
// rate      out        o_valid / i_stall                o_rate_x/y/z, o_is_calibrated, o_found_now
// config    in         i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// one sample per cycle sustained while the rate side does not stall; results pass window stages a, b, c, then d and o
// the ring memory is read and written in the acceptance cycle, sums update as a sample moves from stage b to stage c
// no clearing pass after reset: a ring entry is read on every acceptance, but its value is used only once written
// a stall on the rate side backs up stage by stage; bubbles are filled before o_stall rises
`timescale 1ns / 1ps

module gyro_still_bias_calibrator import gsbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [SmpW-1:0] i_gyro_x,
    input  logic signed [SmpW-1:0] i_gyro_y,
    input  logic signed [SmpW-1:0] i_gyro_z,
    input  logic [TickW-1:0]      i_now_tick,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [RateW-1:0] o_rate_x,
    output logic signed [RateW-1:0] o_rate_y,
    output logic signed [RateW-1:0] o_rate_z,
    output logic                  o_is_calibrated,
    output logic                  o_found_now,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CfgIdxW-1:0]    i_cfg_index,
    input  logic [CfgDataW-1:0]   i_cfg_data
);

    localparam int VarW = 2 * SumW + 1;

    t_axes            in_smp;
    logic             win_valid;
    logic             win_stall;
    t_stats           win_stats;

    logic [LimitW-1:0]    r_var_limit;
    logic [IntervalW-1:0] r_min_interval;

    logic                 r_d_valid;
    t_stats               r_d_stats;
    logic [2*SumW-1:0]    r_d_sum2 [3];
    logic [SmpW-1:0]      r_d_mean [3];

    logic                 r_bias_latched;
    logic [SmpW-1:0]      r_bias [3];
    logic [LastW-1:0]     r_last;

    logic                 r_o_valid;
    logic [RateW-1:0]     r_o_rate [3];
    logic                 r_o_cal;
    logic                 r_o_found;

    logic                 rdy_o;
    logic                 rdy_d;

    logic signed [2*SumW-1:0] sum2  [3];
    logic [SumW-1:0]          sum_r [3];
    logic signed [VarW-1:0]   vdiff [3];
    logic [2:0]               below;
    logic signed [LastW:0]    gate_lhs;
    logic                     gate_ok;
    logic                     found;
    logic [SmpW-1:0]          bias_sel [3];
    logic [RateW-1:0]         rate [3];

    assign in_smp = {i_gyro_z, i_gyro_y, i_gyro_x};

    gsbc_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (in_smp),
        .i_tick   (i_now_tick),
        .o_valid  (win_valid),
        .i_stall  (win_stall),
        .o_stats  (win_stats)
    );

    assign rdy_o     = !r_o_valid || !i_stall;
    assign rdy_d     = !r_d_valid || rdy_o;
    assign win_stall = !rdy_d;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_limit    <= LimitW'(VarLimitReset);
            r_min_interval <= IntervalW'(MinIntervalReset);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CfgVarLimit:    r_var_limit    <= i_cfg_data[LimitW-1:0];
                CfgMinInterval: r_min_interval <= i_cfg_data[IntervalW-1:0];
                default: ;
            endcase
        end
    end

    // stage d: square of the window sum and the mean rounded toward zero
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sum2[a]  = $signed(win_stats.sum[a]) * $signed(win_stats.sum[a]);
            sum_r[a] = win_stats.sum[a]
                     + (win_stats.sum[a][SumW-1] ? SumW'(WindowSamples - 1) : '0);
        end
    end

    // stage o: variance test, tick gate and bias removal
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            vdiff[a] = $signed({{(VarW-SqW){1'b0}}, r_d_stats.sq[a]})
                     - $signed({1'b0, r_d_sum2[a] >> WindowLog2});
            below[a] = vdiff[a] < $signed({{(VarW-LimitW){1'b0}}, r_var_limit});
        end
        gate_lhs = $signed({r_last[LastW-1], r_last})
                 + $signed({{(LastW+1-IntervalW){1'b0}}, r_min_interval});
        gate_ok  = gate_lhs < $signed({{(LastW+1-TickW){1'b0}}, r_d_stats.tick});
        found    = !r_bias_latched && r_d_stats.full && (&below) && gate_ok;
        for (int a = 0; a < 3; a++) begin
            bias_sel[a] = found ? r_d_mean[a] : r_bias[a];
        end
        rate[0] = {bias_sel[0][SmpW-1], bias_sel[0]}
                - {r_d_stats.smp[0][SmpW-1], r_d_stats.smp[0]};
        for (int a = 1; a < 3; a++) begin
            rate[a] = {r_d_stats.smp[a][SmpW-1], r_d_stats.smp[a]}
                    - {bias_sel[a][SmpW-1], bias_sel[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid      <= 1'b0;
            r_o_valid      <= 1'b0;
            r_bias_latched <= 1'b0;
            r_last         <= LastW'(1 - MinIntervalReset);
            for (int a = 0; a < 3; a++) begin
                r_bias[a] <= '0;
            end
        end else begin
            if (rdy_d) begin
                r_d_valid <= win_valid;
            end
            if (rdy_o) begin
                r_o_valid <= r_d_valid;
            end
            if (r_d_valid && rdy_o && found) begin
                r_bias_latched <= 1'b1;
                r_last         <= {1'b0, r_d_stats.tick};
                for (int a = 0; a < 3; a++) begin
                    r_bias[a] <= r_d_mean[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_valid && rdy_d) begin
            r_d_stats <= win_stats;
            for (int a = 0; a < 3; a++) begin
                r_d_sum2[a] <= sum2[a];
                r_d_mean[a] <= sum_r[a][SumW-1 -: SmpW];
            end
        end
        if (r_d_valid && rdy_o) begin
            r_o_cal   <= r_bias_latched || found;
            r_o_found <= found;
            for (int a = 0; a < 3; a++) begin
                r_o_rate[a] <= rate[a];
            end
        end
    end

    assign o_valid         = r_o_valid;
    assign o_rate_x        = r_o_rate[0];
    assign o_rate_y        = r_o_rate[1];
    assign o_rate_z        = r_o_rate[2];
    assign o_is_calibrated = r_o_cal;
    assign o_found_now     = r_o_found;

endmodule

@@ hw/rtl/gsbc_checker.sv @@
`timescale 1ns / 1ps
`include "gyro_still_bias_calibrator_assert.svh"

module gsbc_checker import gsbc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic signed [RateW-1:0] o_rate_x,
    input logic                   o_is_calibrated,
    input logic                   o_found_now
);

    localparam int MaxInFlight = 5;

    logic       r_seen_cal;
    logic [3:0] r_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_cal <= 1'b0;
            r_pend     <= '0;
        end else begin
            if (out_acc && o_is_calibrated) begin
                r_seen_cal <= 1'b1;
            end
            r_pend <= r_pend + {3'b0, in_acc} - {3'b0, out_acc};
        end
    end

    `GSBC_ASSERT_IMP(a_found_is_cal, i_clk, i_rst_n, o_valid && o_found_now, o_is_calibrated, "found transaction without calibrated flag")
    `GSBC_ASSERT_IMP(a_cal_sticky, i_clk, i_rst_n, o_valid && r_seen_cal, o_is_calibrated && !o_found_now, "calibration lost or found twice")
    `GSBC_ASSERT_IMP(a_in_flight, i_clk, i_rst_n, o_valid, (r_pend != 4'd0) && (r_pend <= 4'(MaxInFlight)), "result without matching sample transaction")
    `GSBC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_rate_x) && $stable(o_found_now), "stalled result changed")

endmodule

bind gyro_still_bias_calibrator gsbc_checker u_gsbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_rate_x        (o_rate_x),
    .o_is_calibrated (o_is_calibrated),
    .o_found_now     (o_found_now)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import gsbc_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;
    // tick gate after reset with the longest interval: -999 + 65535
    localparam logic [TickW-1:0] GateShutMax = 32'd64536;
    localparam logic [TickW-1:0] GateOpenMin = 32'd66000;
    localparam int WatchdogLimit = 4000;
    localparam int LongHold = 250;

    typedef struct packed {
        logic signed [RateW-1:0] rx;
        logic signed [RateW-1:0] ry;
        logic signed [RateW-1:0] rz;
        logic                    cal;
        logic                    found;
    } t_rate;

    typedef struct {
        int          x;
        int          y;
        int          z;
        logic [31:0] tick;
        bit          typed;
        int          rx;
        int          ry;
        int          rz;
    } t_probe;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [SmpW-1:0]  i_gyro_x = '0;
    logic signed [SmpW-1:0]  i_gyro_y = '0;
    logic signed [SmpW-1:0]  i_gyro_z = '0;
    logic [TickW-1:0]        i_now_tick = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [RateW-1:0] o_rate_x;
    logic signed [RateW-1:0] o_rate_y;
    logic signed [RateW-1:0] o_rate_z;
    logic                    o_is_calibrated;
    logic                    o_found_now;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CfgIdxW-1:0]      i_cfg_index = '0;
    logic [CfgDataW-1:0]     i_cfg_data = '0;

    // calibrator state as predicted
    t_axes          win_mem [WindowSamples];
    int             wr_slot = 0;
    bit             win_filled = 1'b0;
    bit             bias_set = 1'b0;
    longint         bias [3] = '{0, 0, 0};
    longint         last_accept = 1 - MinIntervalReset;
    logic [LimitW-1:0]    lim_reg = LimitW'(VarLimitReset);
    logic [IntervalW-1:0] ivl_reg = IntervalW'(MinIntervalReset);

    t_rate pending_rates [$];
    t_rate want_rate;
    int    mismatches = 0;
    int    send_idle = 9;
    int    recv_idle = 58;
    int    hold_asked = 0;
    int    hold_served = 0;
    int    hold_left = 0;
    int    quiet_cycles = 0;

    int    stretch_left = 0;
    bit    still_on;
    int    still_amp;
    int    still_base [3];
    int    pat [WindowSamples][3];
    int    pat_pos = 0;

    t_probe probes [14] = '{
        '{0, 0, 0, 32'h0000_0000, 1, 0, 0, 0},
        '{-32768, 32767, -1, 32'hFFFF_FFFF, 1, 32768, 32767, -1},
        '{32767, -32768, 0, 32'h0000_0001, 1, -32767, -32768, 0},
        '{-1, 0, -32768, 32'h0000_0002, 1, 1, 0, -32768},
        '{1, -1, 32767, 32'h8000_0000, 1, -1, -1, 32767},
        '{21845, -21846, 21845, 32'h5555_5555, 1, -21845, -21846, 21845},
        '{-21846, 21845, -21846, 32'hAAAA_AAAA, 1, 21846, 21845, -21846},
        '{-32768, -32768, -32768, 32'h7FFF_FFFF, 1, 32768, -32768, -32768},
        '{32767, 32767, 32767, 32'd1000, 1, -32767, 32767, 32767},
        '{256, -256, 4096, 32'd1001, 0, 0, 0, 0},
        '{-12345, 23456, -345, 32'h0001_0000, 0, 0, 0, 0},
        '{7, 7, 7, 32'hFFFF_FFFE, 0, 0, 0, 0},
        '{-7, 0, 3000, 32'h0000_FC18, 0, 0, 0, 0},
        '{32000, -31999, 1, 32'h1234_5678, 0, 0, 0, 0}
    };

    gyro_still_bias_calibrator i_dut (.*);

    always #5 i_clk = ~i_clk;

    // scaled variance of one axis over the window, mean truncated toward zero
    function automatic longint axis_spread(input int a, output longint mean);
        longint s, sum, sq;
        int i;
        sum = 0;
        sq = 0;
        for (i = 0; i < WindowSamples; i++) begin
            s = $signed(win_mem[i][a]);
            sum += s;
            sq += s * s;
        end
        mean = sum / WindowSamples;
        return sq - (sum * sum) / WindowSamples;
    endfunction

    function automatic t_rate advance_calibrator(input logic signed [SmpW-1:0] gx, gy, gz,
                                                 input logic [TickW-1:0] tick);
        t_rate r;
        longint gate, now, lim;
        longint means [3];
        bit hit;
        int a;
        win_mem[wr_slot] = {gz, gy, gx};
        wr_slot = (wr_slot + 1) % WindowSamples;
        if (wr_slot == 0) begin
            win_filled = 1'b1;
        end
        hit = 1'b0;
        if (!bias_set && win_filled) begin
            gate = ivl_reg;
            gate += last_accept;
            now = tick;
            lim = lim_reg;
            hit = gate < now;
            for (a = 0; a < 3; a++) begin
                if (axis_spread(a, means[a]) >= lim) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                for (a = 0; a < 3; a++) begin
                    bias[a] = means[a];
                end
                last_accept = now;
                bias_set = 1'b1;
            end
        end
        r.rx = RateW'(bias[0] - longint'(gx));
        r.ry = RateW'(longint'(gy) - bias[1]);
        r.rz = RateW'(longint'(gz) - bias[2]);
        r.cal = bias_set;
        r.found = hit;
        return r;
    endfunction

    function automatic logic [TickW-1:0] pick_tick(input bit gate_open);
        if (gate_open) begin
            return $urandom_range(GateOpenMin, 32'hFFFF_FFFF);
        end else if ($urandom_range(7) == 0) begin
            return GateShutMax;
        end
        return $urandom_range(0, GateShutMax);
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [RateW-1:0] want,
                                        input logic signed [RateW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic offer_sample(input logic signed [SmpW-1:0] gx, gy, gz,
                                input logic [TickW-1:0] tk, output t_rate predicted);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_gyro_x <= gx;
        i_gyro_y <= gy;
        i_gyro_z <= gz;
        i_now_tick <= tk;
        do @(posedge i_clk); while (o_stall);
        predicted = advance_calibrator(gx, gy, gz, tk);
    endtask

    // still stretches with random level and spread, mixed with full-range noise
    task automatic run_random(input int n, input bit gate_open);
        t_rate want;
        int smp [3];
        int k, a;
        for (k = 0; k < n; k++) begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(12, 150);
                still_on = ($urandom_range(3) != 0);
                still_amp = $urandom_range(0, 1 << $urandom_range(0, 7));
                for (a = 0; a < 3; a++) begin
                    still_base[a] = $urandom_range(0, 65535 - 2 * still_amp) - 32768 + still_amp;
                end
            end
            stretch_left--;
            for (a = 0; a < 3; a++) begin
                if (still_on) begin
                    smp[a] = still_base[a] + $urandom_range(0, 2 * still_amp) - still_amp;
                end else begin
                    smp[a] = $urandom_range(0, 65535) - 32768;
                end
            end
            offer_sample(SmpW'(smp[0]), SmpW'(smp[1]), SmpW'(smp[2]),
                         pick_tick(gate_open), want);
            pending_rates.push_back(want);
        end
    endtask

    // a 128-periodic sequence keeps the window contents fixed once filled
    task automatic run_pattern(input int n, input bit gate_open);
        t_rate want;
        int k;
        for (k = 0; k < n; k++) begin
            offer_sample(SmpW'(pat[pat_pos][0]), SmpW'(pat[pat_pos][1]),
                         SmpW'(pat[pat_pos][2]), pick_tick(gate_open), want);
            pending_rates.push_back(want);
            pat_pos = (pat_pos + 1) % WindowSamples;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_rates.size() != 0);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data,
                             input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (last) begin
            i_cfg_valid <= 1'b0;
        end
        case (idx)
            CfgVarLimit: lim_reg = data[LimitW-1:0];
            CfgMinInterval: ivl_reg = data[IntervalW-1:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rates.size() == 0) begin
                $display("%0t: unexpected rate transaction, expected none got %0d %0d %0d %0b %0b",
                         $time, o_rate_x, o_rate_y, o_rate_z, o_is_calibrated, o_found_now);
                mismatches++;
            end else begin
                want_rate = pending_rates.pop_front();
                check_field("rate_x", want_rate.rx, o_rate_x);
                check_field("rate_y", want_rate.ry, o_rate_y);
                check_field("rate_z", want_rate.rz, o_rate_z);
                check_field("is_calibrated", RateW'(want_rate.cal), RateW'(o_is_calibrated));
                check_field("found_now", RateW'(want_rate.found), RateW'(o_found_now));
            end
        end
        if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left <= LongHold;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WatchdogLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int k, a;
        int base [3];
        int amp [3];
        longint widest, v, m;
        t_rate want;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CfgSpareA, $urandom(), 1'b0);
        write_reg(CfgSpareB, $urandom(), 1'b1);

        for (k = 0; k < $size(probes); k++) begin
            offer_sample(SmpW'(probes[k].x), SmpW'(probes[k].y), SmpW'(probes[k].z),
                         probes[k].tick, want);
            if (probes[k].typed) begin
                want.rx = RateW'(probes[k].rx);
                want.ry = RateW'(probes[k].ry);
                want.rz = RateW'(probes[k].rz);
                want.cal = 1'b0;
                want.found = 1'b0;
            end
            pending_rates.push_back(want);
        end
        drain();

        // widest limit, tick gate held shut, long hold on the rate side
        write_reg(CfgVarLimit, 32'hFFFF_FFFF, 1'b0);
        write_reg(CfgMinInterval, 32'hFFFF_FFFF, 1'b1);
        hold_asked++;
        run_random(120, 1'b0);
        drain();

        // zero limit and zero interval, sender pauses until drained midway
        send_idle = 58;
        recv_idle = 9;
        write_reg(CfgVarLimit, 32'h0, 1'b0);
        write_reg(CfgMinInterval, 32'h0, 1'b1);
        run_random(60, 1'b1);
        drain();
        run_random(60, 1'b1);
        drain();

        send_idle = 0;
        recv_idle = 0;
        for (a = 0; a < 3; a++) begin
            amp[a] = $urandom_range(1, 24);
            base[a] = $urandom_range(0, 65535 - 48) - 32768 + 24;
        end
        for (k = 0; k < WindowSamples; k++) begin
            for (a = 0; a < 3; a++) begin
                pat[k][a] = base[a] + $urandom_range(0, 2 * amp[a]) - amp[a];
            end
        end
        write_reg(CfgMinInterval, 32'hFFFF_FFFF, 1'b1);
        run_pattern(WindowSamples, 1'b0);
        drain();

        // limit equal to the largest axis variance must not latch
        widest = 0;
        for (a = 0; a < 3; a++) begin
            v = axis_spread(a, m);
            if (v > widest) begin
                widest = v;
            end
        end
        write_reg(CfgVarLimit, CfgDataW'(widest), 1'b0);
        write_reg(CfgSpareA, CfgDataW'(widest + 1), 1'b0);
        write_reg(CfgSpareB, CfgDataW'(widest + 1), 1'b0);
        write_reg(CfgMinInterval, $urandom_range(0, 65535), 1'b1);
        run_pattern(40, 1'b1);
        drain();

        // one above latches on the next sample, bias fixed afterwards
        write_reg(CfgVarLimit, CfgDataW'(widest + 1), 1'b1);
        run_pattern(16, 1'b1);
        run_random(40, 1'b1);
        drain();
        write_reg(CfgVarLimit, 32'h0, 1'b0);
        write_reg(CfgMinInterval, 32'h0, 1'b1);
        run_random(40, 1'b1);
        drain();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/gsbc_pkg.sv
hw/rtl/gsbc_window.sv
hw/rtl/gyro_still_bias_calibrator.sv
hw/rtl/gsbc_checker.sv
tb/testbench.sv
